// ===== hw/rtl/segx_pkg.sv =====
`default_nettype none
package segx_pkg;
  localparam int COORD_W      = 16;
  localparam int DIFF_W       = COORD_W + 1;
  localparam int PROD_W       = 2 * DIFF_W;
  localparam int CROSS_W      = PROD_W + 1;
  localparam int PARAM_W      = 32;
  localparam int THRESH_W     = 21;
  localparam int FRAC_BITS    = 16;
  localparam int QUEUE_DEPTH  = 4;
  localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(1);

  typedef enum logic [1:0] {
    ST_PARALLEL = 2'd0,
    ST_OUTSIDE  = 2'd1,
    ST_HIT      = 2'd2
  } status_t;

  localparam logic [0:0] REG_THRESH = 1'b0;

  typedef struct packed {
    logic signed [COORD_W-1:0] a_x;
    logic signed [COORD_W-1:0] a_y;
    logic signed [COORD_W-1:0] b_x;
    logic signed [COORD_W-1:0] b_y;
    logic signed [COORD_W-1:0] c_x;
    logic signed [COORD_W-1:0] c_y;
    logic signed [COORD_W-1:0] d_x;
    logic signed [COORD_W-1:0] d_y;
  } in_item_t;

  typedef struct packed {
    logic [1:0]                status;
    logic signed [COORD_W-1:0] hit_x;
    logic signed [COORD_W-1:0] hit_y;
    logic signed [PARAM_W-1:0] param_a;
    logic signed [PARAM_W-1:0] param_b;
  } out_item_t;

  // cross terms handed from front to back
  typedef struct packed {
    logic signed [CROSS_W-1:0] num_a;
    logic signed [CROSS_W-1:0] num_b;
    logic signed [CROSS_W-1:0] den;
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [DIFF_W-1:0]  abx;
    logic signed [DIFF_W-1:0]  aby;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;
endpackage
`default_nettype wire

// ===== hw/rtl/segx_front.sv =====
`default_nettype none
module segx_front import segx_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  input  wire q_stat_t  q_stat,
  output logic          push,
  output entry_t        push_data
);
  logic v1_r, v2_r, v3_r;
  logic en;
  logic signed [DIFF_W-1:0] abx_r, aby_r, cdx_r, cdy_r, acx_r, acy_r;
  logic signed [COORD_W-1:0] ax1_r, ay1_r, ax2_r, ay2_r;
  logic signed [DIFF_W-1:0] abx2_r, aby2_r;
  logic signed [PROD_W-1:0] p0_r, p1_r, p2_r, p3_r, p4_r, p5_r;
  entry_t e_r;

  assign en       = !(v3_r && q_stat.full);
  assign in_stall = !en;
  assign push     = v3_r && !q_stat.full;
  assign push_data = e_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      abx_r <= DIFF_W'(in_data.b_x) - DIFF_W'(in_data.a_x);
      aby_r <= DIFF_W'(in_data.b_y) - DIFF_W'(in_data.a_y);
      cdx_r <= DIFF_W'(in_data.d_x) - DIFF_W'(in_data.c_x);
      cdy_r <= DIFF_W'(in_data.d_y) - DIFF_W'(in_data.c_y);
      acx_r <= DIFF_W'(in_data.a_x) - DIFF_W'(in_data.c_x);
      acy_r <= DIFF_W'(in_data.a_y) - DIFF_W'(in_data.c_y);
      ax1_r <= in_data.a_x;
      ay1_r <= in_data.a_y;
      // products
      p0_r <= cdx_r * acy_r;
      p1_r <= cdy_r * acx_r;
      p2_r <= abx_r * acy_r;
      p3_r <= aby_r * acx_r;
      p4_r <= cdy_r * abx_r;
      p5_r <= cdx_r * aby_r;
      ax2_r  <= ax1_r;
      ay2_r  <= ay1_r;
      abx2_r <= abx_r;
      aby2_r <= aby_r;
      // cross terms
      e_r.num_a <= CROSS_W'(p0_r) - CROSS_W'(p1_r);
      e_r.num_b <= CROSS_W'(p2_r) - CROSS_W'(p3_r);
      e_r.den   <= CROSS_W'(p4_r) - CROSS_W'(p5_r);
      e_r.ax    <= ax2_r;
      e_r.ay    <= ay2_r;
      e_r.abx   <= abx2_r;
      e_r.aby   <= aby2_r;
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/segx_queue.sv =====
`default_nettype none
module segx_queue import segx_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire entry_t push_data,
  input  wire logic   pop,
  output entry_t      pop_data,
  output q_stat_t     stat
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  entry_t mem_r [DEPTH];
  logic [PW-1:0] wr_r, rd_r;
  logic [CW-1:0] cnt_r;

  assign stat.full  = (cnt_r == CW'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign pop_data   = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
      if (pop)  rd_r <= (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
      cnt_r <= cnt_r + CW'(push) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_data;
  end
endmodule
`default_nettype wire

// ===== hw/rtl/segx_back.sv =====
`default_nettype none
module segx_back import segx_pkg::*; #(
  parameter int F = FRAC_BITS
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic [THRESH_W-1:0] thresh,
  input  wire q_stat_t             q_stat,
  output logic                     pop,
  input  wire entry_t              pop_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output out_item_t                out_data
);
  localparam int NW = CROSS_W;
  localparam int DW = NW + PARAM_W;
  localparam int NS = PARAM_W;
  localparam int SW = DIFF_W + PARAM_W + 1;
  localparam logic signed [PARAM_W-1:0] ONE = PARAM_W'(1) << F;
  localparam logic signed [PARAM_W-1:0] PMAX = {1'b0, {(PARAM_W-1){1'b1}}};
  localparam logic signed [PARAM_W-1:0] PMIN = {1'b1, {(PARAM_W-1){1'b0}}};

  typedef struct packed {
    logic [DW-1:0] rem_a, rem_b;
    logic [NW-1:0] d;
    logic [PARAM_W-1:0] q_a, q_b;
    logic big_a, big_b, neg_a, neg_b, par;
    logic signed [COORD_W-1:0] ax, ay;
    logic signed [DIFF_W-1:0] abx, aby;
  } div_t;

  logic en;
  logic p_v_r;
  logic [NW-1:0] na_r, nb_r, d_r;
  logic pna_r, pnb_r, ppar_r;
  logic signed [COORD_W-1:0] pax_r, pay_r;
  logic signed [DIFF_W-1:0] pabx_r, paby_r;
  logic [NS:0] dv_r;
  div_t ds_r [NS+1];
  div_t d0;
  logic [NW-1:0] mag_den;
  logic s_v_r, m_v_r, o_v_r;
  logic signed [PARAM_W-1:0] ua_r, ub_r, ua_nxt, ub_nxt, ua2_r, ub2_r;
  logic [1:0] st_r, st2_r, st_nxt;
  logic signed [COORD_W-1:0] sax_r, say_r, max_r, may_r;
  logic signed [DIFF_W-1:0] sabx_r, saby_r;
  logic signed [DIFF_W+PARAM_W-1:0] px_r, py_r;
  logic signed [SW-1:0] sx, sy;
  out_item_t o_r;

  function automatic logic signed [PARAM_W-1:0] sat(input logic [PARAM_W-1:0] q,
                                                   input logic big, input logic neg);
    if (!neg) return (big || q[PARAM_W-1]) ? PMAX : q;
    return (big || q > PMIN) ? PMIN : -q;
  endfunction

  function automatic logic signed [COORD_W-1:0] hit(input logic signed [SW-1:0] s);
    logic signed [SW-1:0] t;
    t = s[SW-1] ? s + SW'((1 << F) - 1) : s;
    t = t >>> F;
    return t[COORD_W-1:0];
  endfunction

  assign en  = !o_v_r || !out_stall;
  assign pop = en && !q_stat.empty;
  assign out_valid = o_v_r;
  assign out_data  = o_r;
  assign mag_den = pop_data.den[NW-1] ? NW'(-pop_data.den) : NW'(pop_data.den);

  // magnitudes and parallel test
  always_ff @(posedge clk) begin
    if (en) begin
      pna_r  <= pop_data.num_a[NW-1] ^ pop_data.den[NW-1];
      pnb_r  <= pop_data.num_b[NW-1] ^ pop_data.den[NW-1];
      na_r   <= pop_data.num_a[NW-1] ? NW'(-pop_data.num_a) : NW'(pop_data.num_a);
      nb_r   <= pop_data.num_b[NW-1] ? NW'(-pop_data.num_b) : NW'(pop_data.num_b);
      d_r    <= mag_den;
      ppar_r <= (mag_den == '0) || (mag_den < NW'(thresh));
      pax_r  <= pop_data.ax;
      pay_r  <= pop_data.ay;
      pabx_r <= pop_data.abx;
      paby_r <= pop_data.aby;
    end
  end

  always_comb begin
    d0.rem_a = DW'({na_r, F'(0)});
    d0.rem_b = DW'({nb_r, F'(0)});
    d0.d     = d_r;
    d0.q_a   = '0;
    d0.q_b   = '0;
    d0.big_a = d0.rem_a >= {d_r, PARAM_W'(0)};
    d0.big_b = d0.rem_b >= {d_r, PARAM_W'(0)};
    d0.neg_a = pna_r;
    d0.neg_b = pnb_r;
    d0.par   = ppar_r;
    d0.ax    = pax_r;
    d0.ay    = pay_r;
    d0.abx   = pabx_r;
    d0.aby   = paby_r;
  end

  // restoring divider, one quotient bit per stage
  always_ff @(posedge clk) begin
    if (en) ds_r[0] <= d0;
  end
  for (genvar j = 0; j < NS; j++) begin : g_div
    logic [DW-1:0] sub;
    div_t nx;
    assign sub = DW'(ds_r[j].d) << (NS - 1 - j);
    always_comb begin
      nx = ds_r[j];
      if (ds_r[j].rem_a >= sub) begin
        nx.rem_a = ds_r[j].rem_a - sub;
        nx.q_a[NS-1-j] = 1'b1;
      end
      if (ds_r[j].rem_b >= sub) begin
        nx.rem_b = ds_r[j].rem_b - sub;
        nx.q_b[NS-1-j] = 1'b1;
      end
    end
    always_ff @(posedge clk) begin
      if (en) ds_r[j+1] <= nx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
      dv_r  <= '0;
      s_v_r <= 1'b0;
      m_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else if (en) begin
      p_v_r <= pop;
      dv_r  <= {dv_r[NS-1:0], p_v_r};
      s_v_r <= dv_r[NS];
      m_v_r <= s_v_r;
      o_v_r <= m_v_r;
    end
  end

  always_comb begin
    ua_nxt = sat(ds_r[NS].q_a, ds_r[NS].big_a, ds_r[NS].neg_a);
    ub_nxt = sat(ds_r[NS].q_b, ds_r[NS].big_b, ds_r[NS].neg_b);
    if (ds_r[NS].par) begin
      ua_nxt = '0;
      ub_nxt = '0;
      st_nxt = ST_PARALLEL;
    end else if (ua_nxt >= 0 && ua_nxt <= ONE && ub_nxt >= 0 && ub_nxt <= ONE) begin
      st_nxt = ST_HIT;
    end else begin
      st_nxt = ST_OUTSIDE;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ua_r   <= ua_nxt;
      ub_r   <= ub_nxt;
      st_r   <= st_nxt;
      sax_r  <= ds_r[NS].ax;
      say_r  <= ds_r[NS].ay;
      sabx_r <= ds_r[NS].abx;
      saby_r <= ds_r[NS].aby;
      // hit point products
      px_r  <= sabx_r * ua_r;
      py_r  <= saby_r * ua_r;
      ua2_r <= ua_r;
      ub2_r <= ub_r;
      st2_r <= st_r;
      max_r <= sax_r;
      may_r <= say_r;
      o_r.status  <= st2_r;
      o_r.param_a <= ua2_r;
      o_r.param_b <= ub2_r;
      o_r.hit_x   <= (st2_r == ST_HIT) ? hit(sx) : '0;
      o_r.hit_y   <= (st2_r == ST_HIT) ? hit(sy) : '0;
    end
  end

  assign sx = (SW'(max_r) <<< F) + SW'(px_r);
  assign sy = (SW'(may_r) <<< F) + SW'(py_r);
endmodule
`default_nettype wire

// ===== hw/rtl/segment_intersection_core.sv =====
`default_nettype none
// Segment intersection core.
// Input channel in_*: one item holds the endpoints of segments A-B and C-D,
// signed Q12.4. An item is taken at a clock edge with in_valid high and
// in_stall low. Result channel out_*: one item per input item, in order:
// status, hit point (Q12.4) and the two line parameters (Q15.16, saturated).
// Throughput: one item per cycle while out_stall is low. Pipeline: 3 front
// stages, one queue stage, then 37 back stages (magnitudes, divider load,
// 32 divider stages of one quotient bit each, saturation, hit multiply,
// output register). The 32-stage restoring divider sets the latency.
// Config: APB-style port, one register at byte address 0, parallel_threshold.
// Write it only while no item is in flight.
// Reset (rst_n low, synchronous) empties the pipes and the queue and sets the
// threshold to 1. out_stall high with out_valid high holds the back pipe;
// the front keeps accepting until the small queue fills, then raises in_stall.
module segment_intersection_core import segx_pkg::*; #(
  parameter int PARAM_FRAC_BITS = FRAC_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_item_t        out_data,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  logic [THRESH_W-1:0] thresh_r;
  q_stat_t q_stat;
  logic push, pop;
  entry_t push_data, pop_data;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_THRESH) ? 32'(thresh_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESH_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2] == REG_THRESH) begin
      thresh_r <= cfg_pwdata[THRESH_W-1:0];
    end
  end

  segx_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .q_stat, .push, .push_data
  );

  segx_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst_n, .push, .push_data, .pop, .pop_data, .stat(q_stat)
  );

  segx_back #(.F(PARAM_FRAC_BITS)) u_back (
    .clk, .rst_n, .thresh(thresh_r), .q_stat, .pop, .pop_data,
    .out_valid, .out_stall, .out_data
  );
endmodule
`default_nettype wire
